FILE: sv/tksd_pkg.sv
// Shared types and byte constants for the terminal key sequence decoder.
package tksd_pkg;

    typedef enum logic [4:0] {
        KEY_PRINTABLE      = 5'd0,
        KEY_DELETE         = 5'd1,
        KEY_CTRL_DELETE    = 5'd2,
        KEY_ARROW          = 5'd3,
        KEY_CTRL_ARROW     = 5'd4,
        KEY_ALT_ARROW      = 5'd5,
        KEY_END            = 5'd6,
        KEY_HOME           = 5'd7,
        KEY_PGUP           = 5'd8,
        KEY_PGDN           = 5'd9,
        KEY_SAVE           = 5'd10,
        KEY_DISCARD        = 5'd11,
        KEY_EXIT           = 5'd12,
        KEY_SAVE_AS        = 5'd13,
        KEY_MANUAL         = 5'd14,
        KEY_BACKSPACE      = 5'd15,
        KEY_ENTER          = 5'd16,
        KEY_CTRL_BACKSPACE = 5'd17,
        KEY_CTRL_X         = 5'd18,
        KEY_COMMENT        = 5'd19,
        KEY_INVALID        = 5'd20
    } key_kind_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_ESC   = 4'd1,
        PH_CSI   = 4'd2,
        PH_C3    = 4'd3,
        PH_C3S   = 4'd4,
        PH_C3S5  = 4'd5,
        PH_C1    = 4'd6,
        PH_C1S   = 4'd7,
        PH_C1S5  = 4'd8,
        PH_C1S3  = 4'd9,
        PH_C5    = 4'd10,
        PH_C6    = 4'd11
    } phase_t;

    typedef struct packed {
        logic      emit;
        key_kind_t kind;
        phase_t    phase;
    } dec_result_t;

    localparam logic [7:0] CH_BEL       = 8'd7;
    localparam logic [7:0] CH_STX       = 8'd2;
    localparam logic [7:0] CH_BS        = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_LF        = 8'd10;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_ETB       = 8'd23;
    localparam logic [7:0] CH_CAN       = 8'd24;
    localparam logic [7:0] CH_ESC       = 8'd27;
    localparam logic [7:0] CH_US        = 8'd31;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_TILDE     = 8'd126;
    localparam logic [7:0] CH_DEL       = 8'd127;
    localparam logic [7:0] CH_ONE       = 8'd49;
    localparam logic [7:0] CH_THREE     = 8'd51;
    localparam logic [7:0] CH_FIVE      = 8'd53;
    localparam logic [7:0] CH_SIX       = 8'd54;
    localparam logic [7:0] CH_SEMICOLON = 8'd59;
    localparam logic [7:0] CH_UPPER_A   = 8'd65;
    localparam logic [7:0] CH_UPPER_D   = 8'd68;
    localparam logic [7:0] CH_UPPER_F   = 8'd70;
    localparam logic [7:0] CH_UPPER_H   = 8'd72;
    localparam logic [7:0] CH_UPPER_S   = 8'd83;
    localparam logic [7:0] CH_BRACKET   = 8'd91;
    localparam logic [7:0] CH_LOWER_C   = 8'd99;
    localparam logic [7:0] CH_LOWER_D   = 8'd100;
    localparam logic [7:0] CH_LOWER_M   = 8'd109;
    localparam logic [7:0] CH_LOWER_Q   = 8'd113;
    localparam logic [7:0] CH_LOWER_S   = 8'd115;

endpackage

FILE: sv/tksd_decode.sv
// Combinational decode of one byte against the current parse phase.
module tksd_decode
(
    input  tksd_pkg::phase_t      phase,
    input  logic [7:0]            byte_in,
    output tksd_pkg::dec_result_t res
);

    logic letter;

    assign letter = (byte_in >= tksd_pkg::CH_UPPER_A) && (byte_in <= tksd_pkg::CH_UPPER_D);

    always_comb
    begin
        res.emit  = 1'b1;
        res.kind  = tksd_pkg::KEY_INVALID;
        res.phase = tksd_pkg::PH_IDLE;
        case (phase)
            tksd_pkg::PH_ESC:
            begin
                case (byte_in)
                    tksd_pkg::CH_BRACKET:
                    begin
                        res.emit  = 1'b0;
                        res.phase = tksd_pkg::PH_CSI;
                    end
                    tksd_pkg::CH_LOWER_S: res.kind = tksd_pkg::KEY_SAVE;
                    tksd_pkg::CH_LOWER_C: res.kind = tksd_pkg::KEY_DISCARD;
                    tksd_pkg::CH_LOWER_D: res.kind = tksd_pkg::KEY_CTRL_DELETE;
                    tksd_pkg::CH_LOWER_Q: res.kind = tksd_pkg::KEY_EXIT;
                    tksd_pkg::CH_UPPER_S: res.kind = tksd_pkg::KEY_SAVE_AS;
                    tksd_pkg::CH_LOWER_M: res.kind = tksd_pkg::KEY_MANUAL;
                    default:              res.kind = tksd_pkg::KEY_INVALID;
                endcase
            end
            tksd_pkg::PH_CSI:
            begin
                if (letter)
                begin
                    res.kind = tksd_pkg::KEY_ARROW;
                end
                else
                begin
                    case (byte_in)
                        tksd_pkg::CH_THREE:
                        begin
                            res.emit  = 1'b0;
                            res.phase = tksd_pkg::PH_C3;
                        end
                        tksd_pkg::CH_ONE:
                        begin
                            res.emit  = 1'b0;
                            res.phase = tksd_pkg::PH_C1;
                        end
                        tksd_pkg::CH_FIVE:
                        begin
                            res.emit  = 1'b0;
                            res.phase = tksd_pkg::PH_C5;
                        end
                        tksd_pkg::CH_SIX:
                        begin
                            res.emit  = 1'b0;
                            res.phase = tksd_pkg::PH_C6;
                        end
                        tksd_pkg::CH_UPPER_F: res.kind = tksd_pkg::KEY_END;
                        tksd_pkg::CH_UPPER_H: res.kind = tksd_pkg::KEY_HOME;
                        default:              res.kind = tksd_pkg::KEY_INVALID;
                    endcase
                end
            end
            tksd_pkg::PH_C3:
            begin
                if (byte_in == tksd_pkg::CH_TILDE)
                begin
                    res.kind = tksd_pkg::KEY_DELETE;
                end
                else if (byte_in == tksd_pkg::CH_SEMICOLON)
                begin
                    res.emit  = 1'b0;
                    res.phase = tksd_pkg::PH_C3S;
                end
            end
            tksd_pkg::PH_C3S:
            begin
                if (byte_in == tksd_pkg::CH_FIVE)
                begin
                    res.emit  = 1'b0;
                    res.phase = tksd_pkg::PH_C3S5;
                end
            end
            tksd_pkg::PH_C3S5:
            begin
                if (byte_in == tksd_pkg::CH_TILDE)
                begin
                    res.kind = tksd_pkg::KEY_CTRL_DELETE;
                end
            end
            tksd_pkg::PH_C1:
            begin
                if (byte_in == tksd_pkg::CH_SEMICOLON)
                begin
                    res.emit  = 1'b0;
                    res.phase = tksd_pkg::PH_C1S;
                end
            end
            tksd_pkg::PH_C1S:
            begin
                if (byte_in == tksd_pkg::CH_FIVE)
                begin
                    res.emit  = 1'b0;
                    res.phase = tksd_pkg::PH_C1S5;
                end
                else if (byte_in == tksd_pkg::CH_THREE)
                begin
                    res.emit  = 1'b0;
                    res.phase = tksd_pkg::PH_C1S3;
                end
            end
            tksd_pkg::PH_C1S5:
            begin
                if (letter)
                begin
                    res.kind = tksd_pkg::KEY_CTRL_ARROW;
                end
            end
            tksd_pkg::PH_C1S3:
            begin
                if (letter)
                begin
                    res.kind = tksd_pkg::KEY_ALT_ARROW;
                end
            end
            tksd_pkg::PH_C5:
            begin
                if (byte_in == tksd_pkg::CH_TILDE)
                begin
                    res.kind = tksd_pkg::KEY_PGUP;
                end
            end
            tksd_pkg::PH_C6:
            begin
                if (byte_in == tksd_pkg::CH_TILDE)
                begin
                    res.kind = tksd_pkg::KEY_PGDN;
                end
            end
            default:
            begin
                // Idle, and any phase code that cannot be reached, decode a lone byte.
                if ((byte_in >= tksd_pkg::CH_SPACE) && (byte_in <= tksd_pkg::CH_TILDE))
                begin
                    res.kind = tksd_pkg::KEY_PRINTABLE;
                end
                else
                begin
                    case (byte_in)
                        tksd_pkg::CH_ESC:
                        begin
                            res.emit  = 1'b0;
                            res.phase = tksd_pkg::PH_ESC;
                        end
                        tksd_pkg::CH_DEL: res.kind = tksd_pkg::KEY_BACKSPACE;
                        tksd_pkg::CH_LF:  res.kind = tksd_pkg::KEY_ENTER;
                        tksd_pkg::CH_CR:  res.kind = tksd_pkg::KEY_ENTER;
                        tksd_pkg::CH_TAB: res.kind = tksd_pkg::KEY_PRINTABLE;
                        tksd_pkg::CH_STX: res.kind = tksd_pkg::KEY_EXIT;
                        tksd_pkg::CH_BS:  res.kind = tksd_pkg::KEY_CTRL_BACKSPACE;
                        tksd_pkg::CH_ETB: res.kind = tksd_pkg::KEY_CTRL_BACKSPACE;
                        tksd_pkg::CH_CAN: res.kind = tksd_pkg::KEY_CTRL_X;
                        tksd_pkg::CH_US:  res.kind = tksd_pkg::KEY_COMMENT;
                        tksd_pkg::CH_BEL: res.kind = tksd_pkg::KEY_MANUAL;
                        default:          res.kind = tksd_pkg::KEY_INVALID;
                    endcase
                end
            end
        endcase
    end

endmodule

FILE: sv/terminal_key_sequence_decoder_top.sv
// Top level of the terminal key sequence decoder: input register, parse phase and result register.
//
// Raw terminal bytes enter on the input channel (in_valid, in_ready, in_byte), one byte
// per handshake. Decoded keys leave on the output channel (out_valid, out_ready,
// key_kind, key_byte). A byte that opens or continues an escape sequence yields no
// word; a byte that completes a key or breaks a sequence yields exactly one.
// An accepted byte is held in the input register, decoded against the parse phase by a
// single layer of compare logic, and its word is loaded into the result register when
// the byte advances, which a stall of the receiver can delay. One byte can be accepted
// in every cycle while the output is not stalled; the parse phase is updated as each
// byte advances out of the input register.
// When the receiver stalls, the result register holds its word and the input register
// holds its byte; in_ready falls only once both are full. A byte that gives no word
// still moves on while the output is stalled.
// Reset returns the parse phase to idle and empties both registers.
module terminal_key_sequence_decoder_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] key_kind,
    output logic [7:0] key_byte
);

    logic                  hold_valid_reg;
    logic [7:0]            hold_byte_reg;
    tksd_pkg::phase_t      phase_reg;
    logic                  out_valid_reg;
    tksd_pkg::key_kind_t   kind_reg;
    logic [7:0]            byte_reg;
    tksd_pkg::dec_result_t dec;
    logic                  advance;
    logic                  out_free;

    tksd_decode u_decode
    (
        .phase   (phase_reg),
        .byte_in (hold_byte_reg),
        .res     (dec)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = hold_valid_reg && (!dec.emit || out_free);
    assign in_ready = !hold_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= tksd_pkg::PH_IDLE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                hold_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg <= dec.phase;
            end
            if (advance && dec.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_byte_reg <= in_byte;
        end
        if (advance && dec.emit)
        begin
            kind_reg <= dec.kind;
            byte_reg <= hold_byte_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_kind  = kind_reg;
    assign key_byte  = byte_reg;

endmodule
